// ===== design/qgpg_pkg.sv =====
package qgpg_pkg;

	// Field and internal widths.
	localparam int COORD_W = 24;
	localparam int CALC_W  = 32;
	localparam int SIDE_W  = 4;
	localparam int DSR_W   = 3;
	localparam int IDX_W   = 6;
	localparam int CFG_IDX_W = 2;

	// Grid side limits.
	localparam int MAX_SIDE = 8;
	localparam int MIN_SIDE = 2;

	// Divider: quotient bits produced per cycle and steps per division.
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = CALC_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

	typedef logic signed [CALC_W-1:0] calc_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_ROW,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	// Which quotient a division produces.
	typedef enum logic [2:0] {
		OP_LSX,
		OP_LSY,
		OP_RSX,
		OP_RSY,
		OP_STX,
		OP_STY
	} div_op_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		calc_t            dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		calc_t quotient;
	} div_rsp_t;

	// Grid point leaving the sequencer, still at full width.
	typedef struct packed {
		logic             valid;
		calc_t            x;
		calc_t            y;
		logic [IDX_W-1:0] index;
		logic             last;
	} point_t;

	// Sign extend a coordinate to the working width.
	function automatic calc_t sext_coord(input coord_t v);
		return calc_t'(v);
	endfunction

	// Saturate a working value to the coordinate range.
	function automatic coord_t sat_coord(input calc_t v);
		calc_t hi;
		calc_t lo;
		hi = calc_t'((1 <<< (COORD_W - 1)) - 1);
		lo = -calc_t'(1 <<< (COORD_W - 1));
		if (v > hi) begin
			return coord_t'(hi);
		end else if (v < lo) begin
			return coord_t'(lo);
		end
		return v[COORD_W-1:0];
	endfunction

	// Clamp a grid side to the supported range.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		if (v < SIDE_W'(MIN_SIDE)) begin
			return SIDE_W'(MIN_SIDE);
		end else if (v > SIDE_W'(MAX_SIDE)) begin
			return SIDE_W'(MAX_SIDE);
		end
		return v;
	endfunction

endpackage

// ===== design/qgpg_div.sv =====
module qgpg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  qgpg_pkg::div_req_t  req,
	output qgpg_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [qgpg_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [qgpg_pkg::DSR_W-1:0]          rem_q;
	logic [qgpg_pkg::DSR_W-1:0]          dsr_q;
	logic [qgpg_pkg::CALC_W-1:0]         quo_q;
	logic                                neg_q;
	logic [qgpg_pkg::CALC_W-1:0]         mag;
	logic [qgpg_pkg::CALC_W-1:0]         quo_nxt;
	logic [qgpg_pkg::DSR_W-1:0]          rem_nxt;
	logic [qgpg_pkg::DSR_W:0]            rem_ext;

	// Magnitude of the dividend; the sign is put back on the quotient.
	assign mag = req.dividend[qgpg_pkg::CALC_W-1] ? qgpg_pkg::CALC_W'(-req.dividend)
		: qgpg_pkg::CALC_W'(req.dividend);

	// One cycle of long division: several quotient bits against a narrow divisor.
	// The remainder stays below the divisor, so one subtract per bit suffices.
	always_comb begin
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		rem_ext = '0;
		for (int k = 0; k < qgpg_pkg::DIV_BITS; k++) begin
			rem_ext = {rem_nxt, quo_nxt[qgpg_pkg::CALC_W-1]};
			quo_nxt = {quo_nxt[qgpg_pkg::CALC_W-2:0], 1'b0};
			if (rem_ext >= {1'b0, dsr_q}) begin
				rem_ext    = rem_ext - {1'b0, dsr_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = rem_ext[qgpg_pkg::DSR_W-1:0];
		end
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == qgpg_pkg::DIV_CNT_W'(qgpg_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dsr_q <= req.divisor;
			neg_q <= req.dividend[qgpg_pkg::CALC_W-1];
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	// Quotient truncated toward zero.
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -qgpg_pkg::calc_t'(quo_q) : qgpg_pkg::calc_t'(quo_q);

endmodule

// ===== design/qgpg_core.sv =====
module qgpg_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  qgpg_pkg::coord_t                 corner_a_x,
	input  qgpg_pkg::coord_t                 corner_a_y,
	input  qgpg_pkg::coord_t                 corner_b_x,
	input  qgpg_pkg::coord_t                 corner_b_y,
	input  qgpg_pkg::coord_t                 corner_c_x,
	input  qgpg_pkg::coord_t                 corner_c_y,
	input  qgpg_pkg::coord_t                 corner_d_x,
	input  qgpg_pkg::coord_t                 corner_d_y,
	input  logic [qgpg_pkg::SIDE_W-1:0]      rows,
	input  logic [qgpg_pkg::SIDE_W-1:0]      cols,
	input  logic                             asym,
	output logic                             busy,
	output qgpg_pkg::point_t                 pt
);

	qgpg_pkg::state_t   state_q, state_nxt;
	qgpg_pkg::div_op_t  op_q, op_nxt;
	qgpg_pkg::div_req_t div_req;
	qgpg_pkg::div_rsp_t div_rsp;

	logic [qgpg_pkg::DSR_W-1:0] row_q, col_q;
	logic [qgpg_pkg::DSR_W-1:0] rows_m1, cols_m1;
	logic [qgpg_pkg::IDX_W-1:0] idx_q;
	logic                       accept;
	logic                       row_last, col_last;

	qgpg_pkg::calc_t lx_q, ly_q, rx_q, ry_q;
	qgpg_pkg::calc_t cx_q, cy_q, dx_q, dy_q;
	qgpg_pkg::calc_t lsx_q, lsy_q, rsx_q, rsy_q;
	qgpg_pkg::calc_t stx_q, sty_q;
	qgpg_pkg::calc_t px_q, py_q;
	qgpg_pkg::calc_t hx, hy;

	logic [qgpg_pkg::SIDE_W-1:0] rows_d, cols_d;

	assign rows_d   = rows - 1'b1;
	assign cols_d   = cols - 1'b1;
	assign rows_m1  = rows_d[qgpg_pkg::DSR_W-1:0];
	assign cols_m1  = cols_d[qgpg_pkg::DSR_W-1:0];
	assign row_last = (row_q == rows_m1);
	assign col_last = (col_q == cols_m1);
	assign accept   = start && (state_q == qgpg_pkg::ST_IDLE);
	assign busy     = (state_q != qgpg_pkg::ST_IDLE);

	// Half column step, truncated toward zero.
	assign hx = (stx_q + qgpg_pkg::calc_t'(stx_q[qgpg_pkg::CALC_W-1])) >>> 1;
	assign hy = (sty_q + qgpg_pkg::calc_t'(sty_q[qgpg_pkg::CALC_W-1])) >>> 1;

	// Shared divider.
	qgpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qgpg_pkg::ST_IDLE;
			op_q    <= qgpg_pkg::OP_LSX;
		end else begin
			state_q <= state_nxt;
			op_q    <= op_nxt;
		end
	end

	// Next state, divider request and point output.
	always_comb begin
		state_nxt        = state_q;
		op_nxt           = op_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = rows_m1;
		pt.valid         = 1'b0;
		pt.index         = idx_q;
		pt.last          = row_last && col_last;
		if (col_q == '0) begin
			pt.x = lx_q;
			pt.y = ly_q;
		end else if (col_last) begin
			pt.x = rx_q;
			pt.y = ry_q;
		end else begin
			pt.x = px_q;
			pt.y = py_q;
		end
		case (state_q)
			qgpg_pkg::ST_IDLE: begin
				if (start) begin
					op_nxt    = qgpg_pkg::OP_LSX;
					state_nxt = qgpg_pkg::ST_ISSUE;
				end
			end
			qgpg_pkg::ST_ISSUE: begin
				div_req.start = 1'b1;
				case (op_q)
					qgpg_pkg::OP_LSX: div_req.dividend = dx_q - lx_q;
					qgpg_pkg::OP_LSY: div_req.dividend = dy_q - ly_q;
					qgpg_pkg::OP_RSX: div_req.dividend = cx_q - rx_q;
					qgpg_pkg::OP_RSY: div_req.dividend = cy_q - ry_q;
					qgpg_pkg::OP_STX: div_req.dividend = rx_q - lx_q;
					default:          div_req.dividend = ry_q - ly_q;
				endcase
				if (op_q == qgpg_pkg::OP_STX || op_q == qgpg_pkg::OP_STY) begin
					div_req.divisor = cols_m1;
				end
				state_nxt = qgpg_pkg::ST_WAIT;
			end
			qgpg_pkg::ST_WAIT: begin
				if (div_rsp.done) begin
					case (op_q)
						qgpg_pkg::OP_LSX: begin
							op_nxt    = qgpg_pkg::OP_LSY;
							state_nxt = qgpg_pkg::ST_ISSUE;
						end
						qgpg_pkg::OP_LSY: begin
							op_nxt    = qgpg_pkg::OP_RSX;
							state_nxt = qgpg_pkg::ST_ISSUE;
						end
						qgpg_pkg::OP_RSX: begin
							op_nxt    = qgpg_pkg::OP_RSY;
							state_nxt = qgpg_pkg::ST_ISSUE;
						end
						qgpg_pkg::OP_RSY: begin
							state_nxt = qgpg_pkg::ST_ROW;
						end
						qgpg_pkg::OP_STX: begin
							op_nxt    = qgpg_pkg::OP_STY;
							state_nxt = qgpg_pkg::ST_ISSUE;
						end
						default: begin
							state_nxt = (asym && row_q != '0) ? qgpg_pkg::ST_SHIFT
								: qgpg_pkg::ST_EMIT;
						end
					endcase
				end
			end
			qgpg_pkg::ST_ROW: begin
				op_nxt    = qgpg_pkg::OP_STX;
				state_nxt = qgpg_pkg::ST_ISSUE;
			end
			qgpg_pkg::ST_SHIFT: begin
				state_nxt = qgpg_pkg::ST_EMIT;
			end
			qgpg_pkg::ST_EMIT: begin
				pt.valid = 1'b1;
				if (col_last) begin
					state_nxt = row_last ? qgpg_pkg::ST_IDLE : qgpg_pkg::ST_ROW;
				end
			end
			default: begin
				state_nxt = qgpg_pkg::ST_IDLE;
			end
		endcase
	end

	// Row, column and point counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			row_q <= '0;
			col_q <= '0;
			idx_q <= '0;
		end else if (state_q == qgpg_pkg::ST_EMIT) begin
			idx_q <= idx_q + 1'b1;
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Coordinate datapath: row ends, edge steps, column steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			lx_q <= qgpg_pkg::sext_coord(corner_a_x);
			ly_q <= qgpg_pkg::sext_coord(corner_a_y);
			rx_q <= qgpg_pkg::sext_coord(corner_b_x);
			ry_q <= qgpg_pkg::sext_coord(corner_b_y);
			cx_q <= qgpg_pkg::sext_coord(corner_c_x);
			cy_q <= qgpg_pkg::sext_coord(corner_c_y);
			dx_q <= qgpg_pkg::sext_coord(corner_d_x);
			dy_q <= qgpg_pkg::sext_coord(corner_d_y);
		end else begin
			case (state_q)
				qgpg_pkg::ST_WAIT: begin
					if (div_rsp.done) begin
						case (op_q)
							qgpg_pkg::OP_LSX: lsx_q <= div_rsp.quotient;
							qgpg_pkg::OP_LSY: lsy_q <= div_rsp.quotient;
							qgpg_pkg::OP_RSX: rsx_q <= div_rsp.quotient;
							qgpg_pkg::OP_RSY: rsy_q <= div_rsp.quotient;
							qgpg_pkg::OP_STX: stx_q <= div_rsp.quotient;
							default:          sty_q <= div_rsp.quotient;
						endcase
					end
				end
				qgpg_pkg::ST_ROW: begin
					// The first row starts at the corners themselves.
					if (row_q != '0) begin
						lx_q <= lx_q + lsx_q;
						ly_q <= ly_q + lsy_q;
						rx_q <= rx_q + rsx_q;
						ry_q <= ry_q + rsy_q;
					end
				end
				qgpg_pkg::ST_SHIFT: begin
					// Odd rows move back by half a step, even rows forward.
					if (row_q[0]) begin
						lx_q <= lx_q - hx;
						ly_q <= ly_q - hy;
						rx_q <= rx_q - hx;
						ry_q <= ry_q - hy;
					end else begin
						lx_q <= lx_q + hx;
						ly_q <= ly_q + hy;
						rx_q <= rx_q + hx;
						ry_q <= ry_q + hy;
					end
				end
				qgpg_pkg::ST_EMIT: begin
					// Running inner point: left end plus column times step.
					px_q <= ((col_q == '0) ? lx_q : px_q) + stx_q;
					py_q <= ((col_q == '0) ? ly_q : py_q) + sty_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/quad_grid_point_generator.sv =====
// Quad grid point generator.
// Request channel: corner_a..corner_d are taken at a rising edge with start high
// and busy low. The block then emits rows*cols grid points in index order, one
// per cycle within a row, each shown for one cycle with point_valid high;
// last_point marks the final point of the request. The receiver cannot stall,
// so points are never held back.
// Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready are
// high; cfg_ready is high whenever no request is in progress. Index 0 is the
// row count, 1 the column count, 2 the pattern mode; other indexes are ignored.
// Timing: one shared divider producing 8 quotient bits a cycle sets the rate.
// A request first runs four divisions for the left and right edge steps, then
// for each row two divisions for the column steps before its points, plus a
// half-step shift on every row after the first in staggered mode. Only one
// request is in progress at a time.
// Reset: configuration returns to 4 rows, 4 columns, symmetric mode, and any
// request in progress is dropped.
module quad_grid_point_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  qgpg_pkg::coord_t                    corner_a_x,
	input  qgpg_pkg::coord_t                    corner_a_y,
	input  qgpg_pkg::coord_t                    corner_b_x,
	input  qgpg_pkg::coord_t                    corner_b_y,
	input  qgpg_pkg::coord_t                    corner_c_x,
	input  qgpg_pkg::coord_t                    corner_c_y,
	input  qgpg_pkg::coord_t                    corner_d_x,
	input  qgpg_pkg::coord_t                    corner_d_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qgpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qgpg_pkg::SIDE_W-1:0]         cfg_data,
	output logic                                point_valid,
	output qgpg_pkg::coord_t                    point_x,
	output qgpg_pkg::coord_t                    point_y,
	output logic [qgpg_pkg::IDX_W-1:0]          point_index,
	output logic                                last_point
);

	logic [qgpg_pkg::SIDE_W-1:0] grid_rows_q, grid_cols_q;
	logic                        pattern_mode_q;
	logic [qgpg_pkg::SIDE_W-1:0] rows_c, cols_c, rows_eff, cols_eff;
	logic                        core_busy;
	qgpg_pkg::point_t            pt;

	assign cfg_ready = !core_busy;
	assign busy      = core_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q    <= qgpg_pkg::SIDE_W'(4);
			grid_cols_q    <= qgpg_pkg::SIDE_W'(4);
			pattern_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qgpg_pkg::CFG_ROWS: grid_rows_q    <= cfg_data;
				qgpg_pkg::CFG_COLS: grid_cols_q    <= cfg_data;
				qgpg_pkg::CFG_MODE: pattern_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the sides, then swap them in staggered mode.
	assign rows_c   = qgpg_pkg::clamp_side(grid_rows_q);
	assign cols_c   = qgpg_pkg::clamp_side(grid_cols_q);
	assign rows_eff = pattern_mode_q ? cols_c : rows_c;
	assign cols_eff = pattern_mode_q ? rows_c : cols_c;

	qgpg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.corner_a_x (corner_a_x),
		.corner_a_y (corner_a_y),
		.corner_b_x (corner_b_x),
		.corner_b_y (corner_b_y),
		.corner_c_x (corner_c_x),
		.corner_c_y (corner_c_y),
		.corner_d_x (corner_d_x),
		.corner_d_y (corner_d_y),
		.rows       (rows_eff),
		.cols       (cols_eff),
		.asym       (pattern_mode_q),
		.busy       (core_busy),
		.pt         (pt)
	);

	// Output register with saturation to the coordinate range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else begin
			point_valid <= pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		point_x     <= qgpg_pkg::sat_coord(pt.x);
		point_y     <= qgpg_pkg::sat_coord(pt.y);
		point_index <= pt.index;
		last_point  <= pt.valid && pt.last;
	end

	// The final point flag only comes with a point.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_point |-> point_valid)
		else $error("last_point without point_valid");

	// A point that is not the final one leaves the block still busy.
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !last_point |-> busy)
		else $error("block idle in the middle of a grid");

	// No point follows the final one before a new request.
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && last_point |=> !point_valid)
		else $error("point emitted after the final point");

	// An accepted request makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

endmodule
